// ----- rtl/cobs_pkg.sv -----
// Shared types and constants for the COBS codec.
// Holds the payload structs, the mode code and the per-item result bundle.
// No dependencies.
`default_nettype none

package cobs_pkg;

  localparam int unsigned ADDR_BITS_DEF = 11;  // internal position counter width
  localparam int unsigned OUT_ADDR_W    = 11;  // width of address and length fields
  localparam int unsigned MAX_RES       = 3;   // results one input item can cause
  localparam int unsigned RES_IDX_W     = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W     = $clog2(MAX_RES + 1);

  localparam logic [7:0] CODE_MAX  = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_MODE_ADDR = 2'd0;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic                  write_valid;
    logic [OUT_ADDR_W-1:0] out_address;
    logic [7:0]            out_value;
    logic                  frame_end;
    logic                  frame_error;
    logic [OUT_ADDR_W-1:0] frame_length;
  } out_item_t;

  // All results of one input item, in delivery order, plus how many there are.
  typedef struct packed {
    out_item_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]    count;
  } step_res_t;

endpackage

`default_nettype wire

// ----- rtl/cobs_cfg.sv -----
// APB-style register slave for the COBS codec: the mode register.
// Depends on cobs_pkg.
`default_nettype none

module cobs_cfg import cobs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output mode_e                      mode_o
);

  mode_e mode_q, mode_d;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR);

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = mode_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_MODE_ADDR) begin
      prdata[0] = mode_q;
    end
  end

  assign mode_o = mode_q;

endmodule

`default_nettype wire

// ----- rtl/cobs_core.sv -----
// Frame state and single-pass step logic of the COBS codec.
// Computes all results of the held item and commits the next state on done.
// Depends on cobs_pkg.
`default_nettype none

module cobs_core import cobs_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mode_e     mode_i,
  input  wire in_item_t  item_i,
  input  wire logic      commit_i,
  output step_res_t      step_o
);

  logic [7:0]           group_code_q, group_code_d;
  logic [ADDR_BITS-1:0] code_slot_q, code_slot_d;
  logic [ADDR_BITS-1:0] write_pos_q, write_pos_d;
  logic [7:0]           remain_q, remain_d;
  logic                 prev_ff_q, prev_ff_d;
  logic                 in_frame_q, in_frame_d;
  logic                 err_q, err_d;

  function automatic out_item_t mk_res(logic wv, logic [ADDR_BITS-1:0] addr,
                                       logic [7:0] val, logic fend, logic ferr,
                                       logic [ADDR_BITS-1:0] flen);
    out_item_t r;
    r.write_valid  = wv;
    r.out_address  = OUT_ADDR_W'(addr);
    r.out_value    = val;
    r.frame_end    = fend;
    r.frame_error  = ferr;
    r.frame_length = OUT_ADDR_W'(flen);
    return r;
  endfunction

  always_comb begin
    logic [7:0]           gc, gc1;
    logic [ADDR_BITS-1:0] cs, wp, wp1;
    logic [7:0]           rem;
    logic                 pff, err, wrote;
    logic [ADDR_BITS-1:0] waddr;
    logic [7:0]           wval;
    logic [RES_CNT_W-1:0] n;

    gc    = group_code_q;
    cs    = code_slot_q;
    wp    = write_pos_q;
    rem   = remain_q;
    pff   = prev_ff_q;
    err   = err_q;
    gc1   = '0;
    wp1   = '0;
    wrote = 1'b0;
    waddr = '0;
    wval  = ZERO_BYTE;
    n     = '0;
    step_o = '0;

    case (mode_i)
      MODE_ENCODE: begin
        if (!in_frame_q) begin
          cs  = '0;
          wp  = ADDR_BITS'(1);
          gc  = 8'd1;
          err = 1'b0;
        end
        if (item_i.in_byte == ZERO_BYTE) begin
          step_o.res[0] = mk_res(1'b1, cs, gc, 1'b0, 1'b0, '0);
          n  = RES_CNT_W'(1);
          gc = 8'd1;
          cs = wp;
          wp = wp + 1'b1;
        end else begin
          step_o.res[0] = mk_res(1'b1, wp, item_i.in_byte, 1'b0, 1'b0, '0);
          n   = RES_CNT_W'(1);
          wp1 = wp + 1'b1;
          gc1 = gc + 8'd1;
          if (gc1 == CODE_MAX) begin
            // full group: close it with a code of 0xFF
            step_o.res[1] = mk_res(1'b1, cs, CODE_MAX, 1'b0, 1'b0, '0);
            n  = RES_CNT_W'(2);
            gc = 8'd1;
            cs = wp1;
            wp = wp1 + 1'b1;
          end else begin
            gc = gc1;
            wp = wp1;
          end
        end
        if (item_i.frame_last) begin
          step_o.res[n[RES_IDX_W-1:0]] = mk_res(1'b1, cs, gc, 1'b1, 1'b0, wp);
          n = n + 1'b1;
        end
      end
      MODE_DECODE: begin
        if (!in_frame_q) begin
          wp  = '0;
          rem = '0;
          pff = 1'b1;
          err = 1'b0;
        end
        if (rem == 8'd0) begin
          if (item_i.in_byte == ZERO_BYTE) begin
            err = 1'b1;
          end else begin
            if (!pff) begin
              // zero between groups
              wrote = 1'b1;
              waddr = wp;
              wval  = ZERO_BYTE;
              wp    = wp + 1'b1;
            end
            rem = item_i.in_byte - 8'd1;
            pff = (item_i.in_byte == CODE_MAX);
          end
        end else begin
          wrote = 1'b1;
          waddr = wp;
          wval  = item_i.in_byte;
          wp    = wp + 1'b1;
          rem   = rem - 8'd1;
        end
        if (item_i.frame_last) begin
          if (rem != 8'd0) begin
            err = 1'b1;
          end
          step_o.res[0] = mk_res(wrote, wrote ? waddr : '0, wrote ? wval : ZERO_BYTE,
                                 1'b1, err, wp);
          n = RES_CNT_W'(1);
        end else if (wrote) begin
          step_o.res[0] = mk_res(1'b1, waddr, wval, 1'b0, err, '0);
          n = RES_CNT_W'(1);
        end
      end
      default: begin
        n = '0;
      end
    endcase

    step_o.count = n;

    group_code_d = gc;
    code_slot_d  = cs;
    write_pos_d  = wp;
    remain_d     = rem;
    prev_ff_d    = pff;
    err_d        = err;
    in_frame_d   = !item_i.frame_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_code_q <= 8'd1;
      code_slot_q  <= '0;
      write_pos_q  <= '0;
      remain_q     <= '0;
      prev_ff_q    <= 1'b0;
      in_frame_q   <= 1'b0;
      err_q        <= 1'b0;
    end else if (commit_i) begin
      group_code_q <= group_code_d;
      code_slot_q  <= code_slot_d;
      write_pos_q  <= write_pos_d;
      remain_q     <= remain_d;
      prev_ff_q    <= prev_ff_d;
      in_frame_q   <= in_frame_d;
      err_q        <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cobs_codec_top.sv -----
// COBS codec top level: input register, result sequencer and output register.
// Depends on cobs_pkg, cobs_cfg and cobs_core.
//
//   port group   dir  width       transfer when
//   in_*         in   in_item_t   in_valid_i  && in_ready_o
//   out_*        out  out_item_t  out_valid_o && out_ready_i
//   APB          in   32-bit      psel && penable && pwrite && pready
//
// One input byte per cycle when each byte causes at most one result and the
// output does not stall. A byte causing k results (at most 3) holds the input
// register while the single output register drains one result per cycle.
// A decode code byte that neither writes nor ends the frame retires with no
// result. Reset clears frame state and mode; the first byte after reset opens
// a frame. Output stalls hold the output register and back up into the input.
`default_nettype none

module cobs_codec_top import cobs_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  mode_e                mode;
  step_res_t            step;
  in_item_t             item_q;
  logic                 item_valid_q;
  logic [RES_IDX_W-1:0] idx_q, idx_d;
  out_item_t            out_q;
  logic                 out_valid_q;
  logic                 out_free, load_out, done;

  cobs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  cobs_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode),
    .item_i   (item_q),
    .commit_i (done),
    .step_o   (step)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // One result per cycle while out_free; retire on the last result, or if none.
  always_comb begin
    load_out = 1'b0;
    done     = 1'b0;
    idx_d    = idx_q;
    if (item_valid_q) begin
      if (step.count == '0) begin
        done = 1'b1;
      end else if (out_free) begin
        load_out = 1'b1;
        if (RES_CNT_W'(idx_q) == step.count - 1'b1) begin
          done = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
    if (done) begin
      idx_d = '0;
    end
  end

  assign in_ready_o = !item_valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (in_valid_i && in_ready_o) begin
        item_valid_q <= 1'b1;
      end else if (done) begin
        item_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= step.res[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- bench/cobs_codec_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cobs_codec_top: directed rows, random frames, both modes.
// Expected writes come from a behavioral COBS model kept in this file; uses cobs_pkg.

module cobs_codec_top_test;
  import cobs_pkg::*;

  localparam int CLK_HALF  = 6;
  localparam int DRAIN     = 8;     // cycles for a silent code byte to retire
  localparam int STALL_MAX = 3000;  // cycles with no transfer before giving up
  localparam int PHASE_ITEMS = 6;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;   // byte, or the mode value for a register row
    logic       last;
    out_item_t  want;   // only used by typed rows
  } dir_row_t;

  localparam out_item_t NO_RESULT = '0;
  localparam logic [7:0] ENC = 8'(MODE_ENCODE);
  localparam logic [7:0] DEC = 8'(MODE_DECODE);

  localparam dir_row_t DIRECTED [24] = '{
    '{ROW_CFG,   ENC,   1'b0, NO_RESULT},
    '{ROW_TYPED, 8'h00, 1'b0, '{1'b1, 11'd0, 8'h01, 1'b0, 1'b0, 11'd0}},
    '{ROW_BYTE,  8'hFF, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h01, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h00, 1'b1, NO_RESULT},
    '{ROW_BYTE,  8'h00, 1'b1, NO_RESULT},
    '{ROW_BYTE,  8'h7F, 1'b0, NO_RESULT},
    // switch to decode with the encode frame still open
    '{ROW_CFG,   DEC,   1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h02, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'hAA, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h00, 1'b1, NO_RESULT},
    // zero code, then a group carrying a zero data byte
    '{ROW_BYTE,  8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h03, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h00, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'hFF, 1'b0, NO_RESULT},
    // full-length code, then the frame ends inside the group
    '{ROW_BYTE,  8'hFF, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h11, 1'b1, NO_RESULT},
    '{ROW_TYPED, 8'h01, 1'b1, '{1'b0, 11'd0, 8'h00, 1'b1, 1'b0, 11'd0}},
    '{ROW_TYPED, 8'h00, 1'b1, '{1'b0, 11'd0, 8'h00, 1'b1, 1'b1, 11'd0}},
    '{ROW_BYTE,  8'h02, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h55, 1'b0, NO_RESULT},
    '{ROW_BYTE,  8'h01, 1'b1, NO_RESULT},
    '{ROW_CFG,   ENC,   1'b0, NO_RESULT},
    '{ROW_BYTE,  8'hFF, 1'b1, NO_RESULT}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cobs_codec_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Codec model state
  mode_e                    cfg_mode;
  logic [7:0]               grp_code;
  logic [ADDR_BITS_DEF-1:0] code_pos;
  logic [ADDR_BITS_DEF-1:0] wr_pos;
  logic [7:0]               dec_left;
  bit                       last_code_ff;
  bit                       frame_open;
  bit                       err_flag;

  out_item_t pending_writes[$];
  out_item_t step_writes[$];
  in_item_t  frame_q[$];
  out_item_t oldest;

  int src_idle;
  int sink_idle;
  int hold_left;
  int bad_results;
  int quiet_cycles;

  function automatic out_item_t write_rec(logic wv, logic [10:0] addr, logic [7:0] val,
                                          logic fend, logic ferr, logic [10:0] flen);
    out_item_t r;
    r.write_valid  = wv;
    r.out_address  = addr;
    r.out_value    = val;
    r.frame_end    = fend;
    r.frame_error  = ferr;
    r.frame_length = flen;
    return r;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("wv=%0d addr=%0d val=%02h end=%0d err=%0d len=%0d", r.write_valid,
                     r.out_address, r.out_value, r.frame_end, r.frame_error,
                     r.frame_length);
  endfunction

  // Work out the buffer writes one byte causes; results land in step_writes.
  task automatic cobs_predict(in_item_t it);
    logic       wrote;
    logic [10:0] addr;
    logic [7:0] val;
    step_writes.delete();
    wrote = 1'b0;
    addr  = '0;
    val   = '0;
    if (cfg_mode == MODE_ENCODE) begin
      if (!frame_open) begin
        code_pos   = '0;
        wr_pos     = ADDR_BITS_DEF'(1);
        grp_code   = 8'd1;
        err_flag   = 1'b0;
        frame_open = 1'b1;
      end
      if (it.in_byte == ZERO_BYTE) begin
        step_writes.push_back(write_rec(1'b1, code_pos, grp_code, 1'b0, 1'b0, '0));
        grp_code = 8'd1;
        code_pos = wr_pos;
        wr_pos   = wr_pos + 1'b1;
      end else begin
        step_writes.push_back(write_rec(1'b1, wr_pos, it.in_byte, 1'b0, 1'b0, '0));
        wr_pos   = wr_pos + 1'b1;
        grp_code = grp_code + 8'd1;
        if (grp_code == CODE_MAX) begin
          step_writes.push_back(write_rec(1'b1, code_pos, CODE_MAX, 1'b0, 1'b0, '0));
          grp_code = 8'd1;
          code_pos = wr_pos;
          wr_pos   = wr_pos + 1'b1;
        end
      end
      if (it.frame_last) begin
        step_writes.push_back(write_rec(1'b1, code_pos, grp_code, 1'b1, 1'b0, wr_pos));
        frame_open = 1'b0;
      end
    end else begin
      if (!frame_open) begin
        wr_pos       = '0;
        dec_left     = '0;
        last_code_ff = 1'b1;
        err_flag     = 1'b0;
        frame_open   = 1'b1;
      end
      if (dec_left == 8'd0) begin
        if (it.in_byte == ZERO_BYTE) begin
          err_flag = 1'b1;
        end else begin
          // a zero goes between groups unless the group before was full length
          if (!last_code_ff) begin
            wrote  = 1'b1;
            addr   = wr_pos;
            val    = ZERO_BYTE;
            wr_pos = wr_pos + 1'b1;
          end
          dec_left     = it.in_byte - 8'd1;
          last_code_ff = (it.in_byte == CODE_MAX);
        end
      end else begin
        wrote    = 1'b1;
        addr     = wr_pos;
        val      = it.in_byte;
        wr_pos   = wr_pos + 1'b1;
        dec_left = dec_left - 8'd1;
      end
      if (it.frame_last) begin
        if (dec_left != 8'd0) err_flag = 1'b1;
        step_writes.push_back(write_rec(wrote, addr, val, 1'b1, err_flag, wr_pos));
        frame_open = 1'b0;
      end else if (wrote) begin
        step_writes.push_back(write_rec(1'b1, addr, val, 1'b0, err_flag, '0));
      end
    end
  endtask

  // Offer one byte, hold it until the transfer, then queue what it should write.
  task automatic offer_byte(in_item_t it, bit typed, out_item_t want);
    while ($urandom_range(99) < src_idle) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk_i); while (!in_ready);
    cobs_predict(it);
    if (typed) pending_writes.push_back(want);
    else foreach (step_writes[k]) pending_writes.push_back(step_writes[k]);
    @(negedge clk_i);
  endtask

  task automatic set_mode(mode_e m);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = REG_MODE_ADDR;
    pwdata  = APB_DATA_W'(m);
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_mode = m;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [7:0] nonzero_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h01;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic in_item_t byte_item(logic [7:0] b);
    in_item_t it;
    it.in_byte    = b;
    it.frame_last = 1'b0;
    return it;
  endfunction

  task automatic make_encode_frame(int len, int zero_pct);
    frame_q.delete();
    repeat (len) begin
      frame_q.push_back(byte_item(($urandom_range(99) < zero_pct) ? ZERO_BYTE
                                                                  : nonzero_byte()));
    end
    frame_q[$].frame_last = 1'b1;
  endtask

  // Mostly well-formed groups; some noise and some frames cut inside a group.
  task automatic make_decode_frame();
    int code;
    int cut;
    frame_q.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 8)) begin
        frame_q.push_back(byte_item(($urandom_range(99) < 30) ? ZERO_BYTE
                                                              : 8'($urandom_range(255))));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        code = $urandom_range(1, 12);
        frame_q.push_back(byte_item(8'(code)));
        repeat (code - 1) frame_q.push_back(byte_item(nonzero_byte()));
      end
      if ($urandom_range(99) < 15 && frame_q.size() > 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) frame_q.delete(frame_q.size() - 1);
      end
    end
    frame_q[$].frame_last = 1'b1;
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) offer_byte(frame_q[k], 1'b0, NO_RESULT);
  endtask

  // Receiver: random back-pressure, plus a long hold when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        bad_results = bad_results + 1;
        $display("%0t ns: unexpected result, expected none, got %s", $time, show(out_data));
      end else begin
        oldest = pending_writes.pop_front();
        if (out_data !== oldest) begin
          bad_results = bad_results + 1;
          $display("%0t ns: result mismatch, expected %s, got %s", $time, show(oldest),
                   show(out_data));
        end
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    in_item_t it;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_left    = 0;
    bad_results  = 0;
    quiet_cycles = 0;
    src_idle     = 36;
    sink_idle    = 71;
    cfg_mode     = MODE_ENCODE;
    grp_code     = 8'd1;
    code_pos     = '0;
    wr_pos       = '0;
    dec_left     = '0;
    last_code_ff = 1'b0;
    frame_open   = 1'b0;
    err_flag     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        set_mode(mode_e'(DIRECTED[r].data[0]));
      end else begin
        it.in_byte    = DIRECTED[r].data;
        it.frame_last = DIRECTED[r].last;
        offer_byte(it, DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle  = (ph == 0) ? 36 : (ph == 1) ? 71 : 0;
      sink_idle = (ph == 0) ? 71 : (ph == 1) ? 36 : 0;
      for (int m = 0; m < 2; m++) begin
        set_mode(m ? MODE_DECODE : MODE_ENCODE);
        if (ph == 2 && m == 0) begin
          // stall the output long enough to back up into the input
          @(posedge clk_i);
          hold_left = 60;
          @(negedge clk_i);
        end
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          if (m) make_decode_frame();
          else make_encode_frame($urandom_range(1, 16), 25);
          send_frame();
          sent = sent + frame_q.size();
        end
        if (ph == 2 && m == 0) begin
          // full run: the last byte fills the group and ends the frame
          make_encode_frame(254, 0);
          send_frame();
        end
      end
    end

    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (bad_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- cobs_codec_top.f -----
rtl/cobs_pkg.sv
rtl/cobs_cfg.sv
rtl/cobs_core.sv
rtl/cobs_codec_top.sv
bench/cobs_codec_top_test.sv
